>>> rtl/cldp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cldp_pkg
// Shared types and character constants for the character token parser.
// ----------------------------------------------------------------------------
package cldp_pkg;

    // Character codes
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;

    // Parser phase; unused codes behave as start of token
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_OPENED = 3'd1,
        PH_ESCAPE = 3'd2,
        PH_CLOSE  = 3'd3,
        PH_DIGITS = 3'd4
    } phase_t;

    // Parser state carried between bytes
    typedef struct packed {
        phase_t     phase;
        logic [7:0] held_value;
        logic       bad_escape;
    } parse_state_t;

    // Token result produced by one step
    typedef struct packed {
        logic       emit;
        logic [7:0] char_value;
        logic       parse_ok;
        logic       byte_taken;
    } parse_result_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

>>> rtl/cldp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cldp_step
// One parse step: next parser state and token result for one text byte.
// ----------------------------------------------------------------------------
module cldp_step
    import cldp_pkg::*;
(
    input  parse_state_t  cur_state,
    input  logic [7:0]    text_byte,
    input  logic          at_text_end,
    output parse_state_t  next_state,
    output parse_result_t result
);

    logic [7:0] digit_val;
    logic [7:0] acc_times_ten;

    // digit value and running number * 10 + digit, wrapping at 8 bits
    assign digit_val     = text_byte - CH_ZERO;
    assign acc_times_ten = {cur_state.held_value[4:0], 3'b000}
                         + {cur_state.held_value[6:0], 1'b0};

    // Next state
    always_comb begin
        next_state = cur_state;
        unique case (cur_state.phase)
            PH_OPENED: begin
                if (at_text_end) begin
                    next_state = '{PH_START, 8'h00, 1'b0};
                end else if (text_byte == CH_BACKSLASH) begin
                    next_state.phase = PH_ESCAPE;
                end else begin
                    next_state.held_value = text_byte;
                    next_state.phase      = PH_CLOSE;
                end
            end
            PH_ESCAPE: begin
                if (at_text_end) begin
                    next_state = '{PH_START, 8'h00, 1'b0};
                end else begin
                    next_state.phase = PH_CLOSE;
                    priority if (text_byte == CH_BACKSLASH) begin
                        next_state.held_value = CH_BACKSLASH;
                    end else if (text_byte == CH_N) begin
                        next_state.held_value = CH_NEWLINE;
                    end else if (text_byte == CH_T) begin
                        next_state.held_value = CH_TAB;
                    end else if (text_byte == CH_QUOTE) begin
                        next_state.held_value = CH_QUOTE;
                    end else begin
                        next_state.bad_escape = 1'b1;
                    end
                end
            end
            PH_CLOSE: begin
                next_state = '{PH_START, 8'h00, 1'b0};
            end
            PH_DIGITS: begin
                if (!at_text_end && is_digit(text_byte)) begin
                    next_state.held_value = acc_times_ten + digit_val;
                end else begin
                    next_state = '{PH_START, 8'h00, 1'b0};
                end
            end
            default: begin
                priority if (at_text_end) begin
                    next_state = '{PH_START, 8'h00, 1'b0};
                end else if (text_byte == CH_QUOTE) begin
                    next_state = '{PH_OPENED, 8'h00, 1'b0};
                end else if (is_digit(text_byte)) begin
                    next_state = '{PH_DIGITS, digit_val, 1'b0};
                end else begin
                    next_state = '{PH_START, 8'h00, 1'b0};
                end
            end
        endcase
    end

    // Result
    always_comb begin
        result = '{1'b0, 8'h00, 1'b0, 1'b0};
        unique case (cur_state.phase)
            PH_OPENED, PH_ESCAPE: begin
                // only end of text closes the token here (failure)
                result.emit = at_text_end;
            end
            PH_CLOSE: begin
                result.emit = 1'b1;
                if (!at_text_end && text_byte == CH_QUOTE) begin
                    result.byte_taken = 1'b1;
                    result.parse_ok   = !cur_state.bad_escape;
                    result.char_value = cur_state.bad_escape ? 8'h00
                                                             : cur_state.held_value;
                end
            end
            PH_DIGITS: begin
                if (at_text_end || !is_digit(text_byte)) begin
                    result.emit       = 1'b1;
                    result.parse_ok   = 1'b1;
                    result.char_value = cur_state.held_value;
                end
            end
            default: begin
                // token start: anything but quote or digit fails untaken
                result.emit = at_text_end
                           || ((text_byte != CH_QUOTE) && !is_digit(text_byte));
            end
        endcase
    end

endmodule

>>> rtl/char_literal_or_decimal_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_literal_or_decimal_parser_unit
// Streaming parser for a quoted character or a decimal byte token.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one text byte per transaction (s_text_byte), with
//   s_at_text_end marking end of text. m_ channel: one token result per
//   finished token (m_char_value, m_parse_ok, m_byte_taken). When
//   m_byte_taken is 0 the sender presents that byte again as the first
//   byte of the next token.
//   Throughput: one byte per cycle while s_ready is high. Each byte is held
//   in an input register and goes through one parse step into the result
//   register, which is written only when it is free or its result is being
//   taken; the result then stays on m_ until m_ready. Bytes that do not close
//   a token produce no result.
//   Stall: while a result waits on m_ready, the input register still holds
//   one byte; s_ready falls only when both registers are full and m_ready
//   is low, and rises again in the cycle the result is taken.
//   Reset (aresetn low, synchronous): both registers empty, parser back at
//   the start of a token.
// ----------------------------------------------------------------------------
module char_literal_or_decimal_parser_unit
    import cldp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_at_text_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_value,
    output logic       m_parse_ok,
    output logic       m_byte_taken
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_end_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;
    logic          out_valid_reg;
    logic [7:0]    out_value_reg;
    logic          out_ok_reg;
    logic          out_taken_reg;
    logic          out_free;
    logic          advance;

    // Pipeline control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_end_reg  <= s_at_text_end;
        end
    end

    // Parse step
    cldp_step u_step (
        .cur_state   (state_reg),
        .text_byte   (in_byte_reg),
        .at_text_end (in_end_reg),
        .next_state  (state_next),
        .result      (step_res)
    );

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{PH_START, 8'h00, 1'b0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && step_res.emit;
        end
        if (advance && step_res.emit) begin
            out_value_reg <= step_res.char_value;
            out_ok_reg    <= step_res.parse_ok;
            out_taken_reg <= step_res.byte_taken;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_char_value = out_value_reg;
    assign m_parse_ok   = out_ok_reg;
    assign m_byte_taken = out_taken_reg;

    // Assertions
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_parse_ok) |-> (m_char_value == 8'h00))
        else $error("failed token carries a nonzero value");

    a_emit_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && step_res.emit) |=>
            (state_reg.phase == PH_START && state_reg.held_value == 8'h00
             && !state_reg.bad_escape))
        else $error("parser did not return to token start after a result");

    a_opened_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_OPENED) |->
            (state_reg.held_value == 8'h00 && !state_reg.bad_escape))
        else $error("stale state after opening quote");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while a register was free");

endmodule
